@@ rtl/float_field_huffman_encoder_unit_defines.svh @@
// Assertion macros shared by the float field Huffman encoder RTL.
`ifndef FLOAT_FIELD_HUFFMAN_ENCODER_UNIT_DEFINES_SVH
`define FLOAT_FIELD_HUFFMAN_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FFHE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FFHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ffhe_pkg.sv @@
// Types and constants of the float field Huffman encoder.
package ffhe_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int MAX_CODE_LEN  = 32;

  localparam int EXP_BITS = 11;
  localparam int MHI_BITS = 20;
  localparam int MLO_BITS = 32;
  localparam int WORD_W   = 64;
  localparam int SIGN_BIT = WORD_W - 1;
  localparam int MHI_LSB  = MLO_BITS;
  localparam int EXP_LSB  = MLO_BITS + MHI_BITS;

  localparam int SYM_W   = 32;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PIECE_W = 33;
  localparam int ENT_W   = CODE_W + LEN_W;

  localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int GRP_SIZE    = 8;
  localparam int GRP_IDX_W   = $clog2(GRP_SIZE);
  localparam int NUM_GRP     = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_ENTRIES = NUM_GRP * GRP_SIZE;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  // Table selects; also the field ids of the three pieces
  localparam logic [1:0] TBL_EXP = 2'd0;
  localparam logic [1:0] TBL_MHI = 2'd1;
  localparam logic [1:0] TBL_MLO = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  table_select;
    logic [6:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_symbol;
    logic [31:0] entry_code;
    logic [5:0]  entry_code_len;
    logic [63:0] word;
  } in_item_t;

  typedef struct packed {
    logic [32:0] piece_bits;
    logic [5:0]  piece_len;
    logic [1:0]  field_id;
    logic        code_hit;
    logic        last_piece;
  } out_item_t;

  // Table write into the symbol store
  typedef struct packed {
    logic             en;
    logic [1:0]       sel;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic [SYM_W-1:0] symbol;
  } cam_wr_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } code_ent_t;

  typedef logic [PAD_ENTRIES-1:0] match_vec_t;

  typedef struct packed {
    logic                 any;
    logic [GRP_IDX_W-1:0] idx;
  } grp_sum_t;

  typedef grp_sum_t [NUM_GRP-1:0] grp_vec_t;

endpackage

@@ rtl/ffhe_ram.sv @@
// Generic single write port RAM with one registered read port.
module ffhe_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 38,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ffhe_cam.sv @@
// Symbol store of the three code tables with per-entry match compare.
module ffhe_cam (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffhe_pkg::cam_wr_t            wr,
  input  logic [ffhe_pkg::WORD_W-1:0]  word,
  output ffhe_pkg::match_vec_t         exp_match,
  output ffhe_pkg::match_vec_t         mhi_match,
  output ffhe_pkg::match_vec_t         mlo_match
);

  import ffhe_pkg::*;

  logic [TABLE_ENTRIES-1:0] exp_valid_r;
  logic [TABLE_ENTRIES-1:0] mhi_valid_r;
  logic [TABLE_ENTRIES-1:0] mlo_valid_r;

  logic [EXP_BITS-1:0] exp_sym_r [TABLE_ENTRIES];
  logic [MHI_BITS-1:0] mhi_sym_r [TABLE_ENTRIES];
  logic [MLO_BITS-1:0] mlo_sym_r [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_valid_r <= '0;
      mhi_valid_r <= '0;
      mlo_valid_r <= '0;
    end else if (wr.en) begin
      case (wr.sel)
        TBL_EXP: exp_valid_r[wr.idx] <= wr.valid;
        TBL_MHI: mhi_valid_r[wr.idx] <= wr.valid;
        TBL_MLO: mlo_valid_r[wr.idx] <= wr.valid;
        default: ;
      endcase
    end
  end

  // removal keeps the symbol; only installs overwrite it
  always_ff @(posedge clk) begin
    if (wr.en && wr.valid) begin
      case (wr.sel)
        TBL_EXP: exp_sym_r[wr.idx] <= wr.symbol[EXP_BITS-1:0];
        TBL_MHI: mhi_sym_r[wr.idx] <= wr.symbol[MHI_BITS-1:0];
        TBL_MLO: mlo_sym_r[wr.idx] <= wr.symbol[MLO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exp_match = '0;
    mhi_match = '0;
    mlo_match = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      exp_match[i] = exp_valid_r[i] && (exp_sym_r[i] == word[EXP_LSB +: EXP_BITS]);
      mhi_match[i] = mhi_valid_r[i] && (mhi_sym_r[i] == word[MHI_LSB +: MHI_BITS]);
      mlo_match[i] = mlo_valid_r[i] && (mlo_sym_r[i] == word[0 +: MLO_BITS]);
    end
  end

endmodule

@@ rtl/float_field_huffman_encoder_unit.sv @@
// Top level of the float field Huffman encoder: pipeline, table RAMs and piece output.
//
//  Channel | Ports                          | Payload      | Moves
//  in      | in_valid, in_ready, in_item    | in_item_t    | table write or word to encode
//  out     | out_valid, out_ready, out_item | out_item_t   | one coded piece
//
// An encode item gives three pieces in order, sent from the register after stage 4.
// The single piece output register loads the next word only as the last piece leaves.
// A write item retires from the input register once no older encode
// still has its code RAM read ahead of it.
// Reset is synchronous and clears every valid mark at once; no clearing pass.
// A stalled out_ready backs up stage by stage into in_ready.
`include "float_field_huffman_encoder_unit_defines.svh"

module float_field_huffman_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffhe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ffhe_pkg::out_item_t out_item
);

  import ffhe_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } pick_t;

  // first set bit inside each group of GRP_SIZE entries
  function automatic grp_vec_t summarize(match_vec_t m);
    grp_vec_t s;
    s = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (m[g*GRP_SIZE + b]) begin
          s[g].any = 1'b1;
          s[g].idx = GRP_IDX_W'(b);
        end
      end
    end
    return s;
  endfunction

  // lowest group with a match wins
  function automatic pick_t pick(grp_vec_t s);
    pick_t p;
    p = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (s[g].any) begin
        p.hit = 1'b1;
        p.idx = IDX_W'(g*GRP_SIZE + int'(s[g].idx));
      end
    end
    return p;
  endfunction

  // ---------------- stage control ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, ser_v_r;
  logic adv1, adv2, adv3, adv4;
  logic s1_is_wr, write_ok, s1_fire;
  logic ser_done, ser_load;
  logic [1:0] cnt_r;

  in_item_t s1_item_r;

  assign s1_is_wr = (s1_item_r.req_type == REQ_WRITE);
  assign ser_done = ser_v_r && out_ready && (cnt_r == TBL_MLO);
  assign ser_load = s4_v_r && (!ser_v_r || ser_done);
  assign adv4     = !s4_v_r || ser_load;
  assign adv3     = !s3_v_r || adv4;
  assign adv2     = !s2_v_r || adv3;
  // an older encode must have read its code RAM by this edge
  assign write_ok = !s2_v_r && (!s3_v_r || adv4);
  assign s1_fire  = s1_v_r && (s1_is_wr ? write_ok : adv2);
  assign adv1     = !s1_v_r || s1_fire;
  assign in_ready = adv1;

  // ---------------- stage 1: input register, table write ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  logic              wr_live;
  logic              idx_ok;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   code_mask;
  code_ent_t         wr_ent;
  cam_wr_t           cam_wr;
  logic [IDX_W-1:0]  wr_idx;

  assign idx_ok  = (32'(s1_item_r.entry_index) < TABLE_ENTRIES);
  assign wr_idx  = IDX_W'(s1_item_r.entry_index);
  assign wr_live = s1_v_r && s1_is_wr && write_ok && idx_ok;

  always_comb begin
    len_sat = s1_item_r.entry_code_len;
    if (s1_item_r.entry_code_len == '0) begin
      len_sat = LEN_W'(1);
    end else if (int'(s1_item_r.entry_code_len) > MAX_CODE_LEN) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end
    code_mask   = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
    wr_ent.code = s1_item_r.entry_code & code_mask[CODE_W-1:0];
    wr_ent.len  = len_sat;
  end

  always_comb begin
    cam_wr.en     = wr_live;
    cam_wr.sel    = s1_item_r.table_select;
    cam_wr.idx    = wr_idx;
    cam_wr.valid  = s1_item_r.entry_valid;
    cam_wr.symbol = s1_item_r.entry_symbol;
  end

  match_vec_t exp_m, mhi_m, mlo_m;

  ffhe_cam u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (cam_wr),
    .word      (s1_item_r.word),
    .exp_match (exp_m),
    .mhi_match (mhi_m),
    .mlo_match (mlo_m)
  );

  // ---------------- stage 2: match vectors ----------------
  logic [WORD_W-1:0] s2_word_r;
  match_vec_t        s2_exp_m_r, s2_mhi_m_r, s2_mlo_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r && !s1_is_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r && !s1_is_wr) begin
      s2_word_r  <= s1_item_r.word;
      s2_exp_m_r <= exp_m;
      s2_mhi_m_r <= mhi_m;
      s2_mlo_m_r <= mlo_m;
    end
  end

  // ---------------- stage 3: group summaries ----------------
  logic [WORD_W-1:0] s3_word_r;
  grp_vec_t          s3_exp_g_r, s3_mhi_g_r, s3_mlo_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      s3_word_r  <= s2_word_r;
      s3_exp_g_r <= summarize(s2_exp_m_r);
      s3_mhi_g_r <= summarize(s2_mhi_m_r);
      s3_mlo_g_r <= summarize(s2_mlo_m_r);
    end
  end

  pick_t exp_p, mhi_p, mlo_p;

  assign exp_p = pick(s3_exp_g_r);
  assign mhi_p = pick(s3_mhi_g_r);
  assign mlo_p = pick(s3_mlo_g_r);

  // ---------------- stage 4: code RAM read ----------------
  code_ent_t exp_ent, mhi_ent, mlo_ent;

  ffhe_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_exp_ram (
    .clk     (clk),
    .wr_en   (wr_live && s1_item_r.entry_valid && (s1_item_r.table_select == TBL_EXP)),
    .wr_addr (wr_idx),
    .wr_data (wr_ent),
    .rd_en   (adv4),
    .rd_addr (exp_p.idx),
    .rd_data (exp_ent)
  );

  ffhe_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_mhi_ram (
    .clk     (clk),
    .wr_en   (wr_live && s1_item_r.entry_valid && (s1_item_r.table_select == TBL_MHI)),
    .wr_addr (wr_idx),
    .wr_data (wr_ent),
    .rd_en   (adv4),
    .rd_addr (mhi_p.idx),
    .rd_data (mhi_ent)
  );

  ffhe_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_mlo_ram (
    .clk     (clk),
    .wr_en   (wr_live && s1_item_r.entry_valid && (s1_item_r.table_select == TBL_MLO)),
    .wr_addr (wr_idx),
    .wr_data (wr_ent),
    .rd_en   (adv4),
    .rd_addr (mlo_p.idx),
    .rd_data (mlo_ent)
  );

  logic [WORD_W-1:0] s4_word_r;
  logic              s4_exp_hit_r, s4_mhi_hit_r, s4_mlo_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_v_r) begin
      s4_word_r    <= s3_word_r;
      s4_exp_hit_r <= exp_p.hit;
      s4_mhi_hit_r <= mhi_p.hit;
      s4_mlo_hit_r <= mlo_p.hit;
    end
  end

  // ---------------- piece build ----------------
  out_item_t p_sexp, p_mhi, p_mlo;
  logic      sign;

  assign sign = s4_word_r[SIGN_BIT];

  always_comb begin
    p_sexp.field_id   = TBL_EXP;
    p_sexp.code_hit   = s4_exp_hit_r;
    p_sexp.last_piece = 1'b0;
    if (s4_exp_hit_r) begin
      p_sexp.piece_bits = (PIECE_W'(sign) << exp_ent.len) | PIECE_W'(exp_ent.code);
      p_sexp.piece_len  = exp_ent.len + LEN_W'(1);
    end else begin
      p_sexp.piece_bits = PIECE_W'({sign, s4_word_r[EXP_LSB +: EXP_BITS]});
      p_sexp.piece_len  = LEN_W'(EXP_BITS + 1);
    end

    p_mhi.field_id   = TBL_MHI;
    p_mhi.code_hit   = s4_mhi_hit_r;
    p_mhi.last_piece = 1'b0;
    if (s4_mhi_hit_r) begin
      p_mhi.piece_bits = PIECE_W'(mhi_ent.code);
      p_mhi.piece_len  = mhi_ent.len;
    end else begin
      p_mhi.piece_bits = PIECE_W'(s4_word_r[MHI_LSB +: MHI_BITS]);
      p_mhi.piece_len  = LEN_W'(MHI_BITS);
    end

    p_mlo.field_id   = TBL_MLO;
    p_mlo.code_hit   = s4_mlo_hit_r;
    p_mlo.last_piece = 1'b1;
    if (s4_mlo_hit_r) begin
      p_mlo.piece_bits = PIECE_W'(mlo_ent.code);
      p_mlo.piece_len  = mlo_ent.len;
    end else begin
      p_mlo.piece_bits = PIECE_W'(s4_word_r[0 +: MLO_BITS]);
      p_mlo.piece_len  = LEN_W'(MLO_BITS);
    end
  end

  // ---------------- piece output register ----------------
  out_item_t sexp_r, mhi_r, mlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= TBL_EXP;
    end else if (ser_load) begin
      ser_v_r <= 1'b1;
      cnt_r   <= TBL_EXP;
    end else if (ser_v_r && out_ready) begin
      if (cnt_r == TBL_MLO) begin
        ser_v_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      sexp_r <= p_sexp;
      mhi_r  <= p_mhi;
      mlo_r  <= p_mlo;
    end
  end

  assign out_valid = ser_v_r;

  always_comb begin
    case (cnt_r)
      TBL_EXP: out_item = sexp_r;
      TBL_MHI: out_item = mhi_r;
      default: out_item = mlo_r;
    endcase
  end

  // ---------------- assertions ----------------
  `FFHE_ASSERT_IMPL(a_wr_after_reads, s1_v_r && s1_is_wr && s1_fire, !s2_v_r, "table write passed an encode that has not read its codes")
  `FFHE_ASSERT_NEXT(a_ram_hold, s4_v_r && !adv4, $stable(exp_ent) && $stable(mhi_ent) && $stable(mlo_ent), "code RAM data changed under a stall")
  `FFHE_ASSERT_IMPL(a_len_range, out_valid, (out_item.piece_len != '0) && (out_item.piece_len <= 6'd33), "piece length out of range")
  `FFHE_ASSERT_NEXT(a_load_start, ser_load, ser_v_r && (cnt_r == TBL_EXP), "new word does not start at the first piece")

endmodule

@@ tb/sv/ffhe_piece_checker.sv @@
// Checker for the float field Huffman encoder: keeps its own code tables and checks every piece.
module ffhe_piece_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ffhe_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ffhe_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  pending,
  output int                  pieces_checked,
  output int                  code_hits
);

  import ffhe_pkg::*;

  logic        tab_valid  [3][TABLE_ENTRIES];
  logic [31:0] tab_symbol [3][TABLE_ENTRIES];
  logic [31:0] tab_code   [3][TABLE_ENTRIES];
  logic [5:0]  tab_len    [3][TABLE_ENTRIES];

  out_item_t expected_pieces [$];

  function automatic int field_width(int t);
    case (t)
      TBL_EXP: return EXP_BITS;
      TBL_MHI: return MHI_BITS;
      default: return MLO_BITS;
    endcase
  endfunction

  // Lowest valid slot with a matching symbol wins.
  function automatic bit find_code(int t, logic [31:0] key,
                                   output logic [31:0] code, output logic [5:0] len);
    code = '0;
    len  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tab_valid[t][i] && tab_symbol[t][i] == key) begin
        code = tab_code[t][i];
        len  = tab_len[t][i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void load_entry(in_item_t it);
    int         t;
    logic [5:0] len;
    t = it.table_select;
    if (it.table_select > TBL_MLO) return;
    // removal drops only the valid mark
    if (!it.entry_valid) begin
      tab_valid[t][it.entry_index] = 1'b0;
      return;
    end
    len = it.entry_code_len;
    if (len == 6'd0) len = 6'd1;
    else if (len > MAX_CODE_LEN) len = 6'(MAX_CODE_LEN);
    tab_valid[t][it.entry_index]  = 1'b1;
    tab_symbol[t][it.entry_index] = it.entry_symbol & 32'((64'd1 << field_width(t)) - 1);
    tab_code[t][it.entry_index]   = it.entry_code & 32'((64'd1 << len) - 1);
    tab_len[t][it.entry_index]    = len;
  endfunction

  function automatic void encode_word(logic [63:0] w);
    out_item_t   pc;
    logic [31:0] key;
    logic [31:0] code;
    logic [5:0]  len;
    bit          hit;
    for (int t = 0; t < 3; t++) begin
      if (t == TBL_EXP) key = 32'(w[EXP_LSB +: EXP_BITS]);
      else if (t == TBL_MHI) key = 32'(w[MHI_LSB +: MHI_BITS]);
      else key = w[MLO_BITS-1:0];
      hit = find_code(t, key, code, len);
      pc = '0;
      pc.piece_bits = hit ? 33'(code) : 33'(key);
      pc.piece_len  = hit ? len : 6'(field_width(t));
      // sign bit goes in front of the exponent piece
      if (t == TBL_EXP) begin
        pc.piece_bits = pc.piece_bits | (33'(w[SIGN_BIT]) << pc.piece_len);
        pc.piece_len  = pc.piece_len + 6'd1;
      end
      pc.field_id   = 2'(t);
      pc.code_hit   = hit;
      pc.last_piece = (t == TBL_MLO);
      expected_pieces.insert(expected_pieces.size(), pc);
    end
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t: piece %0d %s: got %h, expected %h", $time, pieces_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (tab_valid[t, e]) tab_valid[t][e] = 1'b0;
      expected_pieces.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pieces.size() == 0) begin
          note_mismatch("arrived with nothing expected", 64'(out_item), '0);
        end else begin
          want = expected_pieces.pop_front();
          if (out_item.piece_bits !== want.piece_bits)
            note_mismatch("piece_bits", 64'(out_item.piece_bits), 64'(want.piece_bits));
          if (out_item.piece_len !== want.piece_len)
            note_mismatch("piece_len", 64'(out_item.piece_len), 64'(want.piece_len));
          if (out_item.field_id !== want.field_id)
            note_mismatch("field_id", 64'(out_item.field_id), 64'(want.field_id));
          if (out_item.code_hit !== want.code_hit)
            note_mismatch("code_hit", 64'(out_item.code_hit), 64'(want.code_hit));
          if (out_item.last_piece !== want.last_piece)
            note_mismatch("last_piece", 64'(out_item.last_piece), 64'(want.last_piece));
          if (want.code_hit) code_hits++;
        end
        pieces_checked++;
      end
      if (in_valid && in_ready) begin
        if (in_item.req_type == REQ_ENCODE) encode_word(in_item.word);
        else load_entry(in_item);
      end
    end
    pending = expected_pieces.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top: drives table writes and words into the encoder and gives the verdict.
module tb_top;
  import ffhe_pkg::*;

  localparam int RANDOM_ITEMS = 390;
  localparam int QUIET_TAIL   = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  // select value that names no table
  localparam logic [1:0] SEL_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  bit          idle_on;
  int          n_writes;
  int          n_words;
  int          stall_cycles;
  int          mismatches;
  int          pending;
  int          pieces_checked;
  int          code_hits;
  logic [31:0] fav_sym [3][6];

  always #5 clk = ~clk;

  float_field_huffman_encoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  ffhe_piece_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .mismatches    (mismatches),
    .pending       (pending),
    .pieces_checked(pieces_checked),
    .code_hits     (code_hits)
  );

  function automatic logic [31:0] field_mask(int t);
    case (t)
      TBL_EXP: return 32'((64'd1 << EXP_BITS) - 1);
      TBL_MHI: return 32'((64'd1 << MHI_BITS) - 1);
      default: return 32'((64'd1 << MLO_BITS) - 1);
    endcase
  endfunction

  // Mostly reuse a few symbols per table so that lookups hit and collide.
  function automatic logic [31:0] pick_symbol(int t);
    if ($urandom_range(0, 99) < 70) return fav_sym[t][$urandom_range(0, 5)];
    return $urandom & field_mask(t);
  endfunction

  function automatic in_item_t mk_write(logic [1:0] sel, int idx, logic ent_valid,
                                        logic [31:0] sym, logic [31:0] code,
                                        logic [5:0] len);
    in_item_t it;
    it.req_type       = REQ_WRITE;
    it.table_select   = sel;
    it.entry_index    = 7'(idx);
    it.entry_valid    = ent_valid;
    it.entry_symbol   = sym;
    it.entry_code     = code;
    it.entry_code_len = len;
    it.word           = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t mk_encode(logic [63:0] w);
    in_item_t it;
    it.req_type       = REQ_ENCODE;
    it.table_select   = 2'($urandom);
    it.entry_index    = 7'($urandom);
    it.entry_valid    = 1'($urandom);
    it.entry_symbol   = $urandom;
    it.entry_code     = $urandom;
    it.entry_code_len = 6'($urandom);
    it.word           = w;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.req_type == REQ_ENCODE) n_words++;
    else n_writes++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side back-pressure
  initial begin
    int unsigned hold;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Stalled for %0d cycles with %0d pieces outstanding", stall_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  sel;
    logic [31:0] sym;
    logic [5:0]  len;
    int          t;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    idle_on   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      fav_sym[k][0] = field_mask(k);
      fav_sym[k][1] = '0;
      for (int j = 2; j < 6; j++) fav_sym[k][j] = $urandom & field_mask(k);
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty tables, priority, removal, saturation, ignored select
    send_item(mk_encode(64'h0));
    send_item(mk_encode(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(mk_write(TBL_EXP, 5, 1'b1, 32'h0000_03FF, 32'h0000_0005, 6'd3));
    send_item(mk_write(TBL_EXP, 2, 1'b1, 32'hFFFF_FBFF, 32'hFFFF_FFFF, 6'd0));
    send_item(mk_encode({1'b1, 11'h3FF, 20'h12345, 32'h0BAD_F00D}));
    send_item(mk_write(TBL_EXP, 2, 1'b0, 32'h0, 32'h0, 6'd4));
    send_item(mk_encode({1'b1, 11'h3FF, 20'h12345, 32'h0BAD_F00D}));
    send_item(mk_write(TBL_MHI, 127, 1'b1, 32'hFFFA_BCDE, 32'hFFFF_FFFF, 6'd63));
    send_item(mk_write(TBL_MLO, 0, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 6'd32));
    send_item(mk_write(TBL_MLO, 1, 1'b1, 32'h0, 32'hFFFF_FFFF, 6'd5));
    send_item(mk_write(SEL_UNUSED, 3, 1'b1, 32'h0, 32'h1, 6'd1));
    send_item(mk_encode({1'b1, 11'h3FF, 20'hABCDE, 32'hFFFF_FFFF}));
    send_item(mk_encode({1'b0, 11'h7FF, 20'h00000, 32'h0000_0000}));
    send_item(mk_write(TBL_EXP, 0, 1'b1, 32'h0000_07FF, 32'hFFFF_FFFF, 6'd32));
    send_item(mk_write(TBL_MHI, 0, 1'b1, 32'hABCDE, 32'h0, 6'd33));
    send_item(mk_encode({1'b1, 11'h7FF, 20'hABCDE, 32'h0000_0000}));
    send_item(mk_write(TBL_MLO, 1, 1'b0, 32'h0, 32'h0, 6'd1));
    send_item(mk_write(TBL_MHI, 10, 1'b1, 32'hFFFF_FFFF, 32'h0, 6'd1));
    send_item(mk_encode({1'b0, 11'h000, 20'hFFFFF, 32'h0000_0000}));
    send_item(mk_write(TBL_MLO, 127, 1'b1, 32'h8000_0001, 32'hAAAA_AAAA, 6'd31));
    send_item(mk_encode({1'b1, 11'h000, 20'h00000, 32'h8000_0001}));
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0)
        idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      if ($urandom_range(0, 99) < 35) begin
        sel = ($urandom_range(0, 15) == 0) ? SEL_UNUSED : 2'($urandom_range(0, 2));
        t   = (sel > TBL_MLO) ? int'(TBL_MLO) : int'(sel);
        sym = pick_symbol(t) | ($urandom & ~field_mask(t));
        len = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(1, MAX_CODE_LEN));
        send_item(mk_write(sel,
                           ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, TABLE_ENTRIES - 1),
                           ($urandom_range(0, 4) != 0), sym, $urandom, len));
      end else begin
        send_item(mk_encode({1'($urandom), 11'(pick_symbol(TBL_EXP)),
                             20'(pick_symbol(TBL_MHI)), pick_symbol(TBL_MLO)}));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d table writes and %0d words; %0d pieces checked, %0d from table codes",
             n_writes, n_words, pieces_checked, code_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d pieces never arrived", mismatches, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ffhe_pkg.sv
rtl/ffhe_ram.sv
rtl/ffhe_cam.sv
rtl/float_field_huffman_encoder_unit.sv
tb/sv/ffhe_piece_checker.sv
tb/sv/tb_top.sv
